/* rtl/riwq_pkg.sv */
// ----------------------------------------------------------------------------
// riwq_pkg
// Shared types and codes for the reorderable identifier wait queue: command
// kinds, move modes, status codes, sequencer states and the cell control word.
// ----------------------------------------------------------------------------
package riwq_pkg;

   // Field widths of one request and one response
   localparam int KIND_W   = 3;
   localparam int ID_W     = 64;
   localparam int POS_W    = 8;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int FPOS_W   = 6;
   localparam int QCNT_W   = 7;

   // Command kinds
   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FIND   = 3'd4;

   // Move target modes
   localparam logic [MODE_W-1:0] MODE_ABS  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TAIL = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_FIND,
      ST_PLAN,
      ST_APPLY
   } seq_state_type;

   // Control word broadcast to every cell of the chain
   typedef struct packed {
      logic cmp;         // compare stored identifier against the request
      logic apply;       // update stored identifier this cycle
      logic shift;       // cells inside the range take a neighbor's entry
      logic take_right;  // 1: take right neighbor, 0: take left neighbor
      logic write;       // the cell at the write index loads the request id
   } cell_ctrl_type;

endpackage

/* rtl/riwq_cell.sv */
// ----------------------------------------------------------------------------
// riwq_cell
// One queue slot: holds an identifier, compares it against the request and
// loads from its left neighbor, its right neighbor or the request.
// ----------------------------------------------------------------------------
module riwq_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 7,
   parameter int IDX_W      = 6
) (
   input  logic                        clock,
   input  riwq_pkg::cell_ctrl_type     ctrl,
   input  logic [riwq_pkg::ID_W-1:0]   cmd_id,
   input  logic [CNT_W-1:0]            count,
   input  logic [CNT_W-1:0]            range_lo,
   input  logic [CNT_W-1:0]            range_hi,
   input  logic [IDX_W-1:0]            wr_pos,
   input  logic [riwq_pkg::ID_W-1:0]   left_entry,
   input  logic [riwq_pkg::ID_W-1:0]   right_entry,
   output logic [riwq_pkg::ID_W-1:0]   entry,
   output logic                        match
);
   import riwq_pkg::*;

   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [ID_W-1:0] entry_ff;
   logic [ID_W-1:0] entry_in;
   logic            match_ff;
   logic            match_in;
   logic            in_range;

   assign in_range = (MY_CNT >= range_lo) && (MY_CNT <= range_hi);

   // Pick the next identifier: request write wins over a shift
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.apply) begin
         if (ctrl.write && (wr_pos == MY_IDX)) begin
            entry_in = cmd_id;
         end else if (ctrl.shift && in_range) begin
            entry_in = ctrl.take_right ? right_entry : left_entry;
         end
      end
   end

   // Flag an occupied slot that holds the requested identifier
   assign match_in = (entry_ff == cmd_id) && (MY_CNT < count);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.cmp) begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

/* rtl/riwq_first_match.sv */
// ----------------------------------------------------------------------------
// riwq_first_match
// Picks the lowest cell whose match flag is set and registers its index.
// ----------------------------------------------------------------------------
module riwq_first_match #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic              clock,
   input  logic              capture,
   input  logic [DEPTH-1:0]  match_vec,
   output logic              hit,
   output logic [IDX_W-1:0]  hit_index
);
   import riwq_pkg::*;

   logic [DEPTH-1:0] first_oh;
   logic [IDX_W-1:0] index_in;
   logic             hit_ff;
   logic [IDX_W-1:0] index_ff;

   // Keep only the lowest set flag; each bit looks at all flags below it
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         first_oh[i] = match_vec[i] &&
                       !(|(match_vec & DEPTH'((DEPTH'(1) << i) - DEPTH'(1))));
      end
   end

   // Encode the one-hot pick into a binary index
   always_comb begin
      index_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_oh[i]) begin
            index_in = index_in | IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         hit_ff   <= |match_vec;
         index_ff <= index_in;
      end
   end

   assign hit       = hit_ff;
   assign hit_index = index_ff;

endmodule

/* rtl/riwq_seq.sv */
// ----------------------------------------------------------------------------
// riwq_seq
// Command sequencer: latches a request, steps through compare, pick and plan,
// then drives the shift over the cell chain and issues the response.
// ----------------------------------------------------------------------------
module riwq_seq #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [riwq_pkg::KIND_W-1:0]   req_kind,
   input  logic [riwq_pkg::ID_W-1:0]     req_job_id,
   input  logic signed [riwq_pkg::POS_W-1:0] req_position,
   input  logic [riwq_pkg::MODE_W-1:0]   req_move_mode,
   input  logic                          hit,
   input  logic [IDX_W-1:0]              hit_index,
   output logic                          capture,
   output riwq_pkg::cell_ctrl_type       ctrl,
   output logic [riwq_pkg::ID_W-1:0]     cmd_id,
   output logic [CNT_W-1:0]              count,
   output logic [CNT_W-1:0]              range_lo,
   output logic [CNT_W-1:0]              range_hi,
   output logic [IDX_W-1:0]              wr_pos,
   output logic                          rsp_valid,
   output logic [riwq_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_found,
   output logic [riwq_pkg::FPOS_W-1:0]   rsp_final_position,
   output logic [riwq_pkg::QCNT_W-1:0]   rsp_queue_count
);
   import riwq_pkg::*;

   localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   seq_state_type state_ff, state_in;

   logic [KIND_W-1:0]       kind_ff;
   logic [ID_W-1:0]         id_ff;
   logic signed [POS_W-1:0] pos_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic [CNT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]    wr_pos_ff, wr_pos_in;
   logic                shift_ff, shift_in, right_ff, right_in, write_ff, write_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                found_ff, found_in;
   logic [FPOS_W-1:0]   fpos_ff, fpos_in;
   logic [QCNT_W-1:0]   qcnt_ff;
   logic                rsp_valid_ff;

   logic signed [CW-1:0] cnt_s, pos_s, idx_s, maxp_s, tgt_s;
   logic                 accept;

   function automatic logic signed [CW-1:0] clamp(input logic signed [CW-1:0] v,
                                                  input logic signed [CW-1:0] lo_v,
                                                  input logic signed [CW-1:0] hi_v);
      logic signed [CW-1:0] r;
      r = v;
      if (v < lo_v) begin
         r = lo_v;
      end else if (v > hi_v) begin
         r = hi_v;
      end
      return r;
   endfunction

   assign accept = start && (state_ff == ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_MATCH;
         ST_MATCH: state_in = ST_FIND;
         ST_FIND:  state_in = ST_PLAN;
         ST_PLAN:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      busy       = 1'b1;
      capture    = 1'b0;
      ctrl       = '0;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_MATCH: ctrl.cmp = 1'b1;
         ST_FIND:  capture = 1'b1;
         ST_PLAN:  ;
         ST_APPLY: begin
            ctrl.apply      = 1'b1;
            ctrl.shift      = shift_ff;
            ctrl.take_right = right_ff;
            ctrl.write      = write_ff;
         end
         default:  busy = 1'b1;
      endcase
   end

   // Signed working copies for target arithmetic
   assign cnt_s  = signed'(CW'(count_ff));
   assign pos_s  = CW'(pos_ff);
   assign idx_s  = signed'(CW'(hit_index));
   assign maxp_s = cnt_s - CW'(1);

   // Move target by mode
   always_comb begin
      case (mode_ff)
         MODE_ABS:  tgt_s = clamp(pos_s, '0, maxp_s);
         MODE_REL:  tgt_s = clamp(idx_s + pos_s, '0, maxp_s);
         MODE_TAIL: tgt_s = (pos_s >= 0) ? maxp_s : clamp(maxp_s + pos_s, '0, maxp_s);
         default:   tgt_s = idx_s;
      endcase
   end

   // Plan the shift range, the write and the response
   always_comb begin
      logic signed [CW-1:0] ins_s;
      ins_s     = (kind_ff == KIND_INSERT) ? clamp(pos_s, '0, cnt_s) : cnt_s;
      lo_in     = '0;
      hi_in     = '0;
      wr_pos_in = '0;
      shift_in  = 1'b0;
      right_in  = 1'b0;
      write_in  = 1'b0;
      status_in = STATUS_OK;
      found_in  = 1'b0;
      fpos_in   = '0;
      count_in  = count_ff;
      case (kind_ff)
         KIND_APPEND, KIND_INSERT: begin
            if (count_ff == DEPTH_CNT) begin
               status_in = STATUS_FULL;
            end else begin
               // open a gap at the target by pulling from the left
               lo_in     = ins_s[CNT_W-1:0];
               hi_in     = count_ff;
               wr_pos_in = ins_s[IDX_W-1:0];
               shift_in  = 1'b1;
               write_in  = 1'b1;
               fpos_in   = FPOS_W'(ins_s[IDX_W-1:0]);
               count_in  = count_ff + CNT_W'(1);
            end
         end
         KIND_REMOVE, KIND_MOVE, KIND_FIND: begin
            if (!hit) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               found_in = 1'b1;
               fpos_in  = FPOS_W'(hit_index);
               if (kind_ff == KIND_REMOVE) begin
                  // close the gap by pulling from the right
                  lo_in    = CNT_W'(hit_index);
                  hi_in    = count_ff - CNT_W'(1);
                  shift_in = 1'b1;
                  right_in = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end else if (kind_ff == KIND_MOVE) begin
                  shift_in  = 1'b1;
                  write_in  = 1'b1;
                  wr_pos_in = tgt_s[IDX_W-1:0];
                  fpos_in   = FPOS_W'(tgt_s[IDX_W-1:0]);
                  if (idx_s < tgt_s) begin
                     lo_in    = CNT_W'(hit_index);
                     hi_in    = tgt_s[CNT_W-1:0];
                     right_in = 1'b1;
                  end else begin
                     lo_in    = tgt_s[CNT_W-1:0];
                     hi_in    = CNT_W'(hit_index);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_PLAN);
         if (state_ff == ST_PLAN) begin
            count_ff <= count_in;
         end
      end
   end

   // Hold the request and the plan
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         id_ff   <= req_job_id;
         pos_ff  <= req_position;
         mode_ff <= req_move_mode;
      end
      if (state_ff == ST_PLAN) begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         wr_pos_ff <= wr_pos_in;
         shift_ff  <= shift_in;
         right_ff  <= right_in;
         write_ff  <= write_in;
         status_ff <= status_in;
         found_ff  <= found_in;
         fpos_ff   <= fpos_in;
         qcnt_ff   <= QCNT_W'(count_in);
      end
   end

   assign cmd_id             = id_ff;
   assign count              = count_ff;
   assign range_lo           = lo_ff;
   assign range_hi           = hi_ff;
   assign wr_pos             = wr_pos_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found          = found_ff;
   assign rsp_final_position = fpos_ff;
   assign rsp_queue_count    = qcnt_ff;

endmodule

/* rtl/reorderable_id_wait_queue_core.sv */
// A request accepted while idle steps through compare, first-match pick and
// target plan; its response strobe is raised in the chain update step.
// A new request is taken only after the last one is done: busy stays high from
// acceptance to the end of the response cycle, set by the single shared sequencer.
// Reset clears the entry count and the sequencer; stored identifiers are not
// cleared and are never read beyond the count. The receiver cannot stall.
// ----------------------------------------------------------------------------
// reorderable_id_wait_queue_core
// Ordered wait queue of 64-bit job identifiers held in a chain of cells that
// append, insert, remove, find and move entries by shifting between neighbors.
// ----------------------------------------------------------------------------
module reorderable_id_wait_queue_core #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [riwq_pkg::KIND_W-1:0]       req_kind,
   input  logic [riwq_pkg::ID_W-1:0]         req_job_id,
   input  logic signed [riwq_pkg::POS_W-1:0] req_position,
   input  logic [riwq_pkg::MODE_W-1:0]       req_move_mode,
   output logic                              rsp_valid,
   output logic [riwq_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_found,
   output logic [riwq_pkg::FPOS_W-1:0]       rsp_final_position,
   output logic [riwq_pkg::QCNT_W-1:0]       rsp_queue_count
);
   import riwq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cell_ctrl_type    ctrl;
   logic [ID_W-1:0]  cmd_id;
   logic [CNT_W-1:0] count;
   logic [CNT_W-1:0] range_lo;
   logic [CNT_W-1:0] range_hi;
   logic [IDX_W-1:0] wr_pos;
   logic             capture;
   logic             hit;
   logic [IDX_W-1:0] hit_index;

   logic [ID_W-1:0]        entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] match_vec;

   riwq_seq #(
      .DEPTH (QUEUE_DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_job_id         (req_job_id),
      .req_position       (req_position),
      .req_move_mode      (req_move_mode),
      .hit                (hit),
      .hit_index          (hit_index),
      .capture            (capture),
      .ctrl               (ctrl),
      .cmd_id             (cmd_id),
      .count              (count),
      .range_lo           (range_lo),
      .range_hi           (range_hi),
      .wr_pos             (wr_pos),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_final_position (rsp_final_position),
      .rsp_queue_count    (rsp_queue_count)
   );

   // Chain of cells; the ends feed back their own entry
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_W-1:0] left_entry;
      logic [ID_W-1:0] right_entry;

      if (i == 0) begin : g_left_end
         assign left_entry = entry[i];
      end else begin : g_left
         assign left_entry = entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_right_end
         assign right_entry = entry[i];
      end else begin : g_right
         assign right_entry = entry[i+1];
      end

      riwq_cell #(
         .CELL_INDEX (i),
         .CNT_W      (CNT_W),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cmd_id      (cmd_id),
         .count       (count),
         .range_lo    (range_lo),
         .range_hi    (range_hi),
         .wr_pos      (wr_pos),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry[i]),
         .match       (match_vec[i])
      );
   end

   riwq_first_match #(
      .DEPTH (QUEUE_DEPTH),
      .IDX_W (IDX_W)
   ) u_first_match (
      .clock     (clock),
      .capture   (capture),
      .match_vec (match_vec),
      .hit       (hit),
      .hit_index (hit_index)
   );

endmodule

/* rtl/riwq_checker.sv */
// ----------------------------------------------------------------------------
// riwq_checker
// Port-level checks on request timing and response consistency, bound to the
// queue top level.
// ----------------------------------------------------------------------------
module riwq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [riwq_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_found,
   input logic [riwq_pkg::FPOS_W-1:0]   rsp_final_position
);
   import riwq_pkg::*;

   // Each accepted request is answered by a response strobe
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("response missing four cycles after request");

   // A response ends the command and frees the block
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block still busy after response");

   // A full queue reports no hit and position zero
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> (!rsp_found && (rsp_final_position == '0)))
      else $error("full response carries hit data");

   // A lookup miss reports no hit and position zero
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NOT_FOUND)) |->
         (!rsp_found && (rsp_final_position == '0)))
      else $error("miss response carries hit data");

endmodule

bind reorderable_id_wait_queue_core riwq_checker u_riwq_checker (.*);

/* sim/riwq_response_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riwq_response_checker
// Watches the request and response ports of the wait queue core, runs a
// shadow copy of the identifier queue for every accepted request and compares
// each response strobe, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module riwq_response_checker #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [riwq_pkg::KIND_W-1:0]       req_kind,
   input  logic [riwq_pkg::ID_W-1:0]         req_job_id,
   input  logic signed [riwq_pkg::POS_W-1:0] req_position,
   input  logic [riwq_pkg::MODE_W-1:0]       req_move_mode,
   input  logic                              rsp_valid,
   input  logic [riwq_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                              rsp_found,
   input  logic [riwq_pkg::FPOS_W-1:0]       rsp_final_position,
   input  logic [riwq_pkg::QCNT_W-1:0]       rsp_queue_count,
   output int                                fail_count,
   output int                                pending_count,
   output int                                checked_count,
   output int                                full_hits,
   output int                                miss_hits
);
   import riwq_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [FPOS_W-1:0]   final_position;
      logic [QCNT_W-1:0]   queue_count;
   } queue_response_type;

   // Shadow copy of the queue contents, head at index 0
   logic [ID_W-1:0] shadow_ids[$];
   // Responses predicted but not yet seen on the response port
   queue_response_type expected_responses[$];

   int error_total   = 0;
   int checked_total = 0;
   int full_total    = 0;
   int miss_total    = 0;

   function automatic int clamp_index(input int value, input int lo, input int hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   // Apply one command to the shadow queue and build its response
   task automatic predict_queue_command(
      input  logic [KIND_W-1:0] kind,
      input  logic [ID_W-1:0]   id,
      input  int                pos,
      input  logic [MODE_W-1:0] mode,
      output queue_response_type rsp
   );
      int cnt;
      int idx;
      int target;
      int last_index;
      int cnt_after;
      cnt = shadow_ids.size();
      rsp = '0;
      rsp.status = STATUS_OK;
      case (kind)
         KIND_APPEND, KIND_INSERT: begin
            if (cnt >= QUEUE_DEPTH) begin
               rsp.status = STATUS_FULL;
               full_total++;
            end else begin
               target = (kind == KIND_INSERT) ? clamp_index(pos, 0, cnt) : cnt;
               shadow_ids.insert(target, id);
               rsp.final_position = target[FPOS_W-1:0];
            end
         end
         KIND_REMOVE, KIND_MOVE, KIND_FIND: begin
            // locate the first match from the head
            idx = -1;
            for (int i = cnt - 1; i >= 0; i--)
               if (shadow_ids[i] == id) idx = i;
            if (idx < 0) begin
               rsp.status = STATUS_NOT_FOUND;
               miss_total++;
            end else begin
               rsp.found = 1'b1;
               target = idx;
               if (kind == KIND_REMOVE) begin
                  shadow_ids.delete(idx);
               end else if (kind == KIND_MOVE) begin
                  last_index = cnt - 1;
                  case (mode)
                     MODE_ABS:  target = clamp_index(pos, 0, last_index);
                     MODE_REL:  target = clamp_index(idx + pos, 0, last_index);
                     MODE_TAIL: target = (pos >= 0) ? last_index
                                                    : clamp_index(last_index + pos, 0, last_index);
                     default:   target = idx;
                  endcase
                  shadow_ids.delete(idx);
                  shadow_ids.insert(target, id);
               end
               rsp.final_position = target[FPOS_W-1:0];
            end
         end
         default: begin
            // unused kinds leave the queue alone
         end
      endcase
      cnt_after = shadow_ids.size();
      rsp.queue_count = cnt_after[QCNT_W-1:0];
   endtask

   // Compare responses, then predict newly accepted requests
   always @(posedge clock) begin : monitor
      queue_response_type want;
      queue_response_type got;
      if (reset) begin
         shadow_ids.delete();
         expected_responses.delete();
      end else begin
         if (rsp_valid) begin
            got.status         = rsp_status;
            got.found          = rsp_found;
            got.final_position = rsp_final_position;
            got.queue_count    = rsp_queue_count;
            checked_total++;
            if (expected_responses.size() == 0) begin
               error_total++;
               if (error_total <= MAX_REPORTS)
                  $display("[%0t] unexpected response: status=%0d found=%0d pos=%0d count=%0d",
                           $time, got.status, got.found, got.final_position,
                           got.queue_count);
            end else begin
               // take the oldest prediction
               want = expected_responses[0];
               expected_responses.delete(0);
               if (got.status !== want.status || got.found !== want.found ||
                   got.final_position !== want.final_position ||
                   got.queue_count !== want.queue_count) begin
                  error_total++;
                  if (error_total <= MAX_REPORTS)
                     $display("[%0t] mismatch: expected status=%0d found=%0d pos=%0d count=%0d,",
                              $time, want.status, want.found, want.final_position,
                              want.queue_count,
                              " got status=%0d found=%0d pos=%0d count=%0d",
                              got.status, got.found, got.final_position,
                              got.queue_count);
               end
            end
         end
         if (start && !busy) begin
            predict_queue_command(req_kind, req_job_id, int'(req_position), req_move_mode,
                                  want);
            expected_responses = {expected_responses, want};
         end
      end
      fail_count    <= error_total;
      pending_count <= expected_responses.size();
      checked_count <= checked_total;
      full_hits     <= full_total;
      miss_hits     <= miss_total;
   end

endmodule

/* sim/reorderable_id_wait_queue_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reorderable_id_wait_queue_core_tb
// Drives directed and random queue commands into the wait queue core with
// random sender gaps and drain pauses; a checker beside the core predicts
// and compares every response, and this module reports the verdict.
// ----------------------------------------------------------------------------
module reorderable_id_wait_queue_core_tb;
   import riwq_pkg::*;

   localparam int QUEUE_DEPTH    = 64;
   localparam int POOL_SIZE      = 16;
   localparam int POOL_IDX_W     = $clog2(POOL_SIZE);
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_ITEMS    = 157;
   localparam int QUIET_PHASE    = 4;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 1000;

   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
   localparam logic [MODE_W-1:0] MODE_UNUSED       = 2'd3;

   typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} traffic_mix_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [ID_W-1:0]     req_job_id;
   logic signed [POS_W-1:0] req_position;
   logic [MODE_W-1:0]   req_move_mode;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_found;
   logic [FPOS_W-1:0]   rsp_final_position;
   logic [QCNT_W-1:0]   rsp_queue_count;

   int fail_count;
   int pending_count;
   int checked_count;
   int full_hits;
   int miss_hits;

   logic [ID_W-1:0] id_pool[POOL_SIZE];
   int              kind_total[8];
   int              idle_cycles = 0;

   reorderable_id_wait_queue_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_job_id         (req_job_id),
      .req_position       (req_position),
      .req_move_mode      (req_move_mode),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_final_position (rsp_final_position),
      .rsp_queue_count    (rsp_queue_count)
   );

   riwq_response_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_response_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_job_id         (req_job_id),
      .req_position       (req_position),
      .req_move_mode      (req_move_mode),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_final_position (rsp_final_position),
      .rsp_queue_count    (rsp_queue_count),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count),
      .full_hits          (full_hits),
      .miss_hits          (miss_hits)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Abort when neither a request nor a response moves for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Hold one request until the core accepts it
   task automatic send_request(
      input logic [KIND_W-1:0]     kind,
      input logic [ID_W-1:0]       id,
      input logic signed [POS_W-1:0] pos,
      input logic [MODE_W-1:0]     mode
   );
      start         <= 1'b1;
      req_kind      <= kind;
      req_job_id    <= id;
      req_position  <= pos;
      req_move_mode <= mode;
      do @(posedge clock); while (busy);
      kind_total[kind]++;
   endtask

   // Drop start for a short random gap now and then
   task automatic sender_pause(input bit allow_idle);
      int gap;
      if (allow_idle && $urandom_range(0, 99) < 50) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending until every outstanding response has come back
   task automatic wait_for_responses();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Build one random command weighted by the traffic mix
   task automatic send_random_request(input traffic_mix_type mix);
      int                      pick;
      int                      offset;
      logic [KIND_W-1:0]       kind;
      logic [ID_W-1:0]         id;
      logic signed [POS_W-1:0] pos;
      logic [MODE_W-1:0]       mode;
      pick = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:
            kind = (pick < 45) ? KIND_APPEND : (pick < 75) ? KIND_INSERT :
                   (pick < 83) ? KIND_REMOVE : (pick < 91) ? KIND_MOVE :
                   (pick < 97) ? KIND_FIND   : KIND_UNUSED_FIRST;
         MIX_BALANCED:
            kind = (pick < 18) ? KIND_APPEND : (pick < 36) ? KIND_INSERT :
                   (pick < 54) ? KIND_REMOVE : (pick < 76) ? KIND_MOVE :
                   (pick < 94) ? KIND_FIND   : KIND_UNUSED_FIRST;
         default:
            kind = (pick < 8)  ? KIND_APPEND : (pick < 16) ? KIND_INSERT :
                   (pick < 66) ? KIND_REMOVE : (pick < 82) ? KIND_MOVE :
                   (pick < 96) ? KIND_FIND   : KIND_UNUSED_FIRST;
      endcase
      if (kind == KIND_UNUSED_FIRST)
         kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
      // mostly pool identifiers so lookups hit, sometimes a fresh one
      if ($urandom_range(0, 99) < 90)
         id = id_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
      else
         id = {$urandom, $urandom};
      // mostly positions near the queue span, sometimes the full range
      if ($urandom_range(0, 99) < 70) begin
         offset = $urandom_range(0, 140);
         pos = POS_W'(offset - 70);
      end else begin
         pos = POS_W'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      mode = (pick < 30) ? MODE_ABS : (pick < 60) ? MODE_REL :
             (pick < 90) ? MODE_TAIL : MODE_UNUSED;
      send_request(kind, id, pos, mode);
   endtask

   // Reset, directed commands, random phases, drain and verdict
   initial begin
      traffic_mix_type mix;
      int              unused_total;
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = KIND_APPEND;
      req_job_id    = '0;
      req_position  = '0;
      req_move_mode = MODE_ABS;
      foreach (kind_total[k]) kind_total[k] = 0;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // lookups on the empty queue
      send_request(KIND_FIND,   id_pool[0], 0, MODE_ABS);
      send_request(KIND_REMOVE, id_pool[1], 0, MODE_ABS);
      send_request(KIND_MOVE,   id_pool[2], 0, MODE_ABS);
      sender_pause(1'b1);
      // extreme identifiers, clamped inserts and a duplicate
      send_request(KIND_APPEND, id_pool[0], 0, MODE_ABS);
      send_request(KIND_APPEND, id_pool[1], 0, MODE_ABS);
      send_request(KIND_INSERT, id_pool[2], -128, MODE_ABS);
      send_request(KIND_INSERT, id_pool[3], 127, MODE_ABS);
      send_request(KIND_INSERT, id_pool[2], 1, MODE_ABS);
      send_request(KIND_FIND,   id_pool[2], 0, MODE_ABS);
      sender_pause(1'b1);
      // every move mode at its clamping limits
      send_request(KIND_MOVE, id_pool[2], 127,  MODE_ABS);
      send_request(KIND_MOVE, id_pool[3], -128, MODE_ABS);
      send_request(KIND_MOVE, id_pool[2], -128, MODE_REL);
      send_request(KIND_MOVE, id_pool[2], 127,  MODE_REL);
      send_request(KIND_MOVE, id_pool[3], 0,    MODE_TAIL);
      send_request(KIND_MOVE, id_pool[3], -128, MODE_TAIL);
      send_request(KIND_MOVE, id_pool[3], -2,   MODE_TAIL);
      send_request(KIND_MOVE, id_pool[0], 5,    MODE_UNUSED);
      // unused kinds, then removes of a duplicate and the last match
      for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
         send_request(KIND_W'(k), id_pool[1], 0, MODE_ABS);
      send_request(KIND_REMOVE, id_pool[2], 0, MODE_ABS);
      send_request(KIND_REMOVE, id_pool[1], 0, MODE_ABS);
      send_request(KIND_FIND,   id_pool[1], 0, MODE_ABS);
      wait_for_responses();

      // random phases: fill to full, churn, drain to empty
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         mix = traffic_mix_type'(phase % 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random_request(mix);
            sender_pause(phase != QUIET_PHASE);
         end
         wait_for_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      unused_total = 0;
      for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
         unused_total += kind_total[k];
      $display("Requests: %0d append, %0d insert, %0d remove, %0d move, %0d find,",
               kind_total[KIND_APPEND], kind_total[KIND_INSERT], kind_total[KIND_REMOVE],
               kind_total[KIND_MOVE], kind_total[KIND_FIND],
               " %0d unused kind", unused_total);
      $display("Responses checked: %0d, full-queue rejects: %0d, lookup misses: %0d",
               checked_count, full_hits, miss_hits);
      if (fail_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
